// ===== rtl/ctt_pkg.sv =====
// Shared types and constants for the configuration text tokenizer.
`default_nettype none
package ctt_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ATOM = 2'd1,
    MODE_INT  = 2'd2,
    MODE_STR  = 2'd3
  } mode_t;

  localparam logic [2:0] KIND_EOF  = 3'd0;
  localparam logic [2:0] KIND_ATOM = 3'd1;
  localparam logic [2:0] KIND_INT  = 3'd2;
  localparam logic [2:0] KIND_EQ   = 3'd3;
  localparam logic [2:0] KIND_STR  = 3'd4;
  localparam logic [2:0] KIND_BAD  = 3'd5;

  localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
  localparam logic [7:0] CHAR_QUOTE      = 8'h22;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [31:0] integer_value;
    logic [7:0]  bad_byte;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage
`default_nettype wire

// ===== rtl/ctt_lexer.sv =====
// Lexer state registers and the per-byte token decision logic.
`default_nettype none
module ctt_lexer #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire ctt_pkg::in_item_t item,
  output ctt_pkg::push_t        push
);
  import ctt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  mode_t                  mode, mode_next, fresh_mode;
  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] token_begin, token_begin_next, fresh_begin;
  logic [31:0]            acc, acc_next, fresh_acc;
  logic [OFFSET_BITS-1:0] pos_inc, body_len;
  logic [OFFSET_BITS+15:0] start_ext, len_ext;
  logic [7:0]             c;
  logic [31:0]            digit_val;
  logic                   letter, digit, space, cont, flush, relex, fresh_emit;
  out_item_t              pend, fresh, eof_item;

  always_comb begin
    c         = item.data_byte;
    letter    = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    space     = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    cont      = letter || digit || (c == CHAR_UNDERSCORE) || (c == CHAR_DASH);
    digit_val = {24'b0, c - CHAR_ZERO};
    pos_inc   = (position == POS_MAX) ? position : position + 1'b1;
    body_len  = position - token_begin;
    start_ext = {16'b0, token_begin};
    len_ext   = {16'b0, body_len};

    pend = '0;
    unique case (mode)
      MODE_ATOM: begin
        pend.token_kind   = KIND_ATOM;
        pend.token_start  = start_ext[15:0];
        pend.token_length = len_ext[15:0];
      end
      MODE_INT: begin
        pend.token_kind    = KIND_INT;
        pend.integer_value = acc;
      end
      MODE_STR: begin
        pend.token_kind   = KIND_STR;
        pend.token_start  = start_ext[15:0];
        pend.token_length = len_ext[15:0];
      end
      default: pend = '0;
    endcase

    eof_item             = '0;
    eof_item.token_kind  = KIND_EOF;
    eof_item.last_of_run = 1'b1;

    fresh       = '0;
    fresh_emit  = 1'b0;
    fresh_mode  = MODE_IDLE;
    fresh_begin = token_begin;
    fresh_acc   = acc;
    if (space) begin
      fresh_mode = MODE_IDLE;
    end else if (letter) begin
      fresh_mode  = MODE_ATOM;
      fresh_begin = position;
    end else if (digit) begin
      fresh_mode = MODE_INT;
      fresh_acc  = digit_val;
    end else if (c == CHAR_EQUALS) begin
      fresh_emit       = 1'b1;
      fresh.token_kind = KIND_EQ;
    end else if (c == CHAR_QUOTE) begin
      fresh_mode  = MODE_STR;
      fresh_begin = pos_inc;
    end else begin
      fresh_emit       = 1'b1;
      fresh.token_kind = KIND_BAD;
      fresh.bad_byte   = c;
    end
    fresh.last_of_run = 1'b1;

    push             = '0;
    mode_next        = mode;
    position_next    = position;
    token_begin_next = token_begin;
    acc_next         = acc;
    flush            = 1'b0;
    relex            = 1'b0;

    if (item.is_end) begin
      mode_next = MODE_IDLE;
      if (mode != MODE_IDLE) begin
        push.count  = 2'd2;
        push.first  = pend;
        push.second = eof_item;
      end else begin
        push.count = 2'd1;
        push.first = eof_item;
      end
    end else begin
      position_next = pos_inc;
      unique case (mode)
        MODE_ATOM: flush = !cont;
        MODE_INT: begin
          flush = !digit;
          if (digit) begin
            acc_next = (acc << 3) + (acc << 1) + digit_val;
          end
        end
        MODE_STR: begin
          if (c == CHAR_QUOTE) begin
            mode_next              = MODE_IDLE;
            push.count             = 2'd1;
            push.first             = pend;
            push.first.last_of_run = 1'b1;
          end
        end
        default: relex = 1'b1;
      endcase

      if (flush || relex) begin
        mode_next        = fresh_mode;
        token_begin_next = fresh_begin;
        acc_next         = fresh_acc;
      end

      if (flush && fresh_emit) begin
        push.count  = 2'd2;
        push.first  = pend;
        push.second = fresh;
      end else if (flush) begin
        push.count             = 2'd1;
        push.first             = pend;
        push.first.last_of_run = 1'b1;
      end else if (relex && fresh_emit) begin
        push.count = 2'd1;
        push.first = fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      position    <= '0;
      token_begin <= '0;
      acc         <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      position    <= position_next;
      token_begin <= token_begin_next;
      acc         <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ctt_queue.sv =====
// Result queue that takes up to two tokens per cycle and hands out one.
`default_nettype none
module ctt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             write_en,
  input  wire ctt_pkg::push_t   push,
  input  wire logic             read_en,
  output ctt_pkg::out_item_t    head,
  output logic [ctt_pkg::LEVEL_BITS-1:0] level
);
  import ctt_pkg::*;

  out_item_t             slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next, wr_ptr_plus;
  logic [LEVEL_BITS-1:0] level_next, push_n, pop_n;

  always_comb begin
    push_n      = write_en ? LEVEL_BITS'(push.count) : '0;
    pop_n       = read_en ? LEVEL_BITS'(1) : '0;
    wr_ptr_plus = PTR_BITS'(wr_ptr + 1'b1);
    wr_ptr_next = PTR_BITS'(wr_ptr + push_n[PTR_BITS-1:0]);
    rd_ptr_next = PTR_BITS'(rd_ptr + pop_n[PTR_BITS-1:0]);
    level_next  = LEVEL_BITS'(level + push_n - pop_n);
    head        = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en && (push.count != 2'd0)) begin
      slots[wr_ptr] <= push.first;
    end
    if (write_en && (push.count == 2'd2)) begin
      slots[wr_ptr_plus] <= push.second;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/config_text_tokenizer.sv =====
// Top level of the configuration text tokenizer: lexer and result queue.
// Each token is registered in the result queue when its byte is transferred.
// Throughput: one byte per cycle when not stalled; a byte's two tokens leave singly.
// The four-entry result queue stalls input while it holds three or more tokens.
// Reset clears the lexer state, the position and the queue; no clearing pass is needed.
`default_nettype none
module config_text_tokenizer #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire ctt_pkg::in_item_t  byte_item,
  output logic                    token_valid,
  input  wire logic               token_stall,
  output ctt_pkg::out_item_t      token_item
);
  import ctt_pkg::*;

  push_t                 push;
  logic                  byte_accept, token_accept;
  logic [LEVEL_BITS-1:0] level;

  assign byte_stall   = level > LEVEL_BITS'(QUEUE_DEPTH - 2);
  assign byte_accept  = byte_valid && !byte_stall;
  assign token_valid  = level != '0;
  assign token_accept = token_valid && !token_stall;

  ctt_lexer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lexer (
    .clk   (clk),
    .rst   (rst),
    .accept(byte_accept),
    .item  (byte_item),
    .push  (push)
  );

  ctt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .write_en(byte_accept),
    .push    (push),
    .read_en (token_accept),
    .head    (token_item),
    .level   (level)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_BITS'(QUEUE_DEPTH))
    else $error("result queue level exceeds its depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (level == '0))
    else $error("result queue not empty after reset");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (byte_accept && byte_item.is_end) |-> (push.count != 2'd0))
    else $error("end transfer produced no token");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run))
    else $error("last_of_run misplaced in a token pair");

endmodule
`default_nettype wire
